/* hw/rtl/lpmt_pkg.sv */
// Shared types and constants for the longest-prefix-match trie unit.
package lpmt_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int ROUTE_W = 10;

  localparam logic [LEN_W-1:0] DEPTH_MAX = 6'd32;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_STORED = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DESCEND,
    OP_LINK,
    OP_STORE,
    OP_FULL,
    OP_LOOKUP_END
  } op_t;

  typedef struct packed {
    logic take;
    op_t  op;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic at_end;
    logic has_child;
    logic fresh;
    logic pool_empty;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/lpmt_ctrl.sv */
// Sequencer for the trie walk: decides one step per cycle from datapath status.
module lpmt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  lpmt_pkg::sts_t sts,
  output lpmt_pkg::cmd_t cmd
);
  import lpmt_pkg::*;

  state_t state;
  state_t state_next;
  op_t    walk_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step choice while walking
  always_comb begin
    if (sts.is_lookup) begin
      if (sts.at_end || !sts.has_child) walk_op = OP_LOOKUP_END;
      else                              walk_op = OP_DESCEND;
    end else if (sts.at_end) begin
      walk_op = OP_STORE;
    end else if (sts.has_child && !sts.fresh) begin
      walk_op = OP_DESCEND;
    end else if (sts.pool_empty) begin
      walk_op = OP_FULL;
    end else begin
      walk_op = OP_LINK;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (walk_op == OP_LOOKUP_END || walk_op == OP_STORE || walk_op == OP_FULL) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '{take: 1'b0, op: OP_NONE, emit: 1'b0};
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      S_WALK: begin
        cmd.op = walk_op;
      end
      S_RESULT: begin
        cmd.emit = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/lpmt_dpath.sv */
// Trie datapath: node memory, root node, walk registers, allocator and result register.
module lpmt_dpath #(
  parameter int NODE_COUNT  = 4096,
  parameter int ROUTE_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          kind,
  input  logic [lpmt_pkg::ADDR_W-1:0]   address,
  input  logic [lpmt_pkg::LEN_W-1:0]    prefix_len,
  input  logic [lpmt_pkg::ROUTE_W-1:0]  route_id,
  input  lpmt_pkg::cmd_t                cmd,
  output lpmt_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [lpmt_pkg::ROUTE_W-1:0]  matched_route
);
  import lpmt_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int RW = (ROUTE_COUNT > (1 << ROUTE_W)) ? ROUTE_W : $clog2(ROUTE_COUNT);
  localparam int RID_MAX = ROUTE_COUNT - 1;
  localparam logic [NW:0] NODE_LIMIT = (NW+1)'(NODE_COUNT);

  typedef struct packed {
    logic          has;
    logic [RW-1:0] route;
    logic [NW-1:0] c0;
    logic [NW-1:0] c1;
  } node_t;

  node_t mem [NODE_COUNT];
  node_t rdata;
  node_t root;
  node_t node;
  node_t wr_node;

  logic [NW-1:0]     cur;
  logic [NW-1:0]     child;
  logic [NW:0]       free;
  logic              fresh;
  logic [LEN_W-1:0]  depth;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] addr_sh;
  logic [RW-1:0]     rid;
  logic [RW-1:0]     rid_sat;
  logic              is_lookup;
  logic              found;
  logic [RW-1:0]     best;
  status_t           res_status;
  logic [RW-1:0]     res_route;
  status_t           out_status;
  logic [RW-1:0]     out_route;
  logic              at_root;
  logic              mem_we;
  logic              root_we;

  assign at_root = (cur == '0);

  // fresh nodes were just allocated and are known to be empty
  always_comb begin
    if (fresh)        node = '0;
    else if (at_root) node = root;
    else              node = rdata;
  end

  assign child = addr_sh[ADDR_W-1] ? node.c1 : node.c0;

  always_comb begin
    if (32'(route_id) > 32'(RID_MAX)) rid_sat = RW'(RID_MAX);
    else                               rid_sat = route_id[RW-1:0];
  end

  always_comb begin
    wr_node = node;
    case (cmd.op)
      OP_LINK: begin
        if (addr_sh[ADDR_W-1]) wr_node.c1 = free[NW-1:0];
        else                   wr_node.c0 = free[NW-1:0];
      end
      OP_STORE: begin
        wr_node.has   = 1'b1;
        wr_node.route = rid;
      end
      default: ;
    endcase
  end

  assign mem_we  = !at_root && (cmd.op == OP_LINK || cmd.op == OP_STORE ||
                                (cmd.op == OP_FULL && fresh));
  assign root_we = at_root && (cmd.op == OP_LINK || cmd.op == OP_STORE);

  // node memory: one write, one registered read of the child being descended to
  always_ff @(posedge clk) begin
    if (mem_we) mem[cur] <= wr_node;
    rdata <= mem[child];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      root      <= '0;
      free      <= (NW+1)'(1);
      fresh     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (root_we) root <= wr_node;
      if (cmd.take) fresh <= 1'b0;
      if (cmd.op == OP_LINK) begin
        free  <= free + (NW+1)'(1);
        fresh <= 1'b1;
      end
      if (cmd.emit)        out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur       <= '0;
      depth     <= '0;
      addr_sh   <= address;
      len       <= (prefix_len > DEPTH_MAX) ? DEPTH_MAX : prefix_len;
      rid       <= rid_sat;
      is_lookup <= kind;
      found     <= 1'b0;
      best      <= '0;
    end
    case (cmd.op)
      OP_DESCEND: begin
        if (is_lookup && node.has) begin
          found <= 1'b1;
          best  <= node.route;
        end
        cur     <= child;
        depth   <= depth + LEN_W'(1);
        addr_sh <= addr_sh << 1;
      end
      OP_LINK: begin
        cur     <= free[NW-1:0];
        depth   <= depth + LEN_W'(1);
        addr_sh <= addr_sh << 1;
      end
      OP_STORE: begin
        res_status <= ST_STORED;
        res_route  <= '0;
      end
      OP_FULL: begin
        res_status <= ST_FULL;
        res_route  <= '0;
      end
      OP_LOOKUP_END: begin
        res_status <= (found || node.has) ? ST_HIT : ST_MISS;
        res_route  <= node.has ? node.route : best;
      end
      default: ;
    endcase
    if (cmd.emit) begin
      out_status <= res_status;
      out_route  <= res_route;
    end
  end

  always_comb begin
    sts.is_lookup  = is_lookup;
    sts.at_end     = is_lookup ? (depth == DEPTH_MAX) : (depth == len);
    sts.has_child  = (child != '0);
    sts.fresh      = fresh;
    sts.pool_empty = (free == NODE_LIMIT);
    sts.out_free   = !out_valid || !out_stall;
  end

  assign status        = out_status;
  assign matched_route = ROUTE_W'(out_route);

endmodule

/* hw/rtl/longest_prefix_match_trie_unit.sv */
// Top level of the IPv4 longest-prefix-match binary trie unit.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_stall, kind, address, prefix_len,  | into unit
//          | route_id                                        |
//  output  | out_valid, out_stall, status, matched_route     | out of unit
//
// Flow: one item at a time. A transfer in, then one trie level per cycle,
// then the result register is loaded, then back to idle. A lookup
// visits up to 33 levels; an insert visits levels 0 to its length, clipped
// to 32, fewer when the node store runs out on the way down.
// The per-level cost is set by the single read port of the node memory,
// whose registered read of the child is used in the following cycle.
// Reset: clears the root node and sets the allocator to node 1; no clearing
// pass, as every other node is written when it is allocated.
// Stalls: the result register holds a finished result while the next item
// is taken and walked; a walk only waits if its own result finds the
// register still full.
//
// Node 0 (the root) lives in flops; nodes 1 and up are in the node memory.
// Child link 0 means "no child". Once an insert allocates a node, every
// deeper node is new too, so those levels are written without reading.
module longest_prefix_match_trie_unit #(
  parameter int NODE_COUNT  = 4096,
  parameter int ROUTE_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [lpmt_pkg::ADDR_W-1:0]   address,
  input  logic [lpmt_pkg::LEN_W-1:0]    prefix_len,
  input  logic [lpmt_pkg::ROUTE_W-1:0]  route_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [lpmt_pkg::ROUTE_W-1:0]  matched_route
);
  import lpmt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpmt_dpath #(
    .NODE_COUNT  (NODE_COUNT),
    .ROUTE_COUNT (ROUTE_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .kind          (kind),
    .address       (address),
    .prefix_len    (prefix_len),
    .route_id      (route_id),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .matched_route (matched_route)
  );

endmodule

/* hw/rtl/lpmt_checker.sv */
// Port-level checks for the trie unit, bound to the top level.
module lpmt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         kind,
  input logic [lpmt_pkg::ADDR_W-1:0]  address,
  input logic [lpmt_pkg::LEN_W-1:0]   prefix_len,
  input logic [lpmt_pkg::ROUTE_W-1:0] route_id,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   status,
  input logic [lpmt_pkg::ROUTE_W-1:0] matched_route
);
  import lpmt_pkg::*;

  // a taken item keeps the input side closed through the shortest walk and the result state
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> ##1 in_stall ##1 in_stall)
    else $error("input reopened too soon after a transfer");

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(kind) && $stable(address) &&
                             $stable(prefix_len) && $stable(route_id))
    else $error("stalled input changed");

  // only a lookup hit carries a route id
  a_route_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_HIT) |-> (matched_route == '0))
    else $error("route id on a non-hit result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(matched_route))
    else $error("stalled result changed");

  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result withdrawn without a transfer");

endmodule

bind longest_prefix_match_trie_unit lpmt_checker u_lpmt_checker (.*);
